// ===== sv/il128_pkg.sv =====
// ----------------------------------------------------------------------------
// il128_pkg
// Character codes, widths and digit decode for the literal parser.
// ----------------------------------------------------------------------------
package il128_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned ACC_W   = 2 * HALF_W;
	localparam int unsigned DIGIT_W = 4;

	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_LOWER_X    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UPPER_X    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_F    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_F    = 8'h46;

	typedef enum logic [1:0] {
		KEPT_NONE = 2'd0,
		KEPT_ONE  = 2'd1,
		KEPT_TWO  = 2'd2
	} kept_t;

	typedef struct packed {
		logic               ok;
		logic [DIGIT_W-1:0] value;
	} digit_t;

	function automatic digit_t decode_digit(input logic [CHAR_W-1:0] c, input logic hex);
		digit_t d;
		logic [CHAR_W-1:0] off;
		d   = '{ok: 1'b0, value: '0};
		off = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			off = c - CH_ZERO;
			d   = '{ok: 1'b1, value: off[DIGIT_W-1:0]};
		end else if (hex && c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			off = c - CH_LOWER_A + 8'd10;
			d   = '{ok: 1'b1, value: off[DIGIT_W-1:0]};
		end else if (hex && c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			off = c - CH_UPPER_A + 8'd10;
			d   = '{ok: 1'b1, value: off[DIGIT_W-1:0]};
		end
		return d;
	endfunction

endpackage

// ===== sv/integer_literal_to_128bit.sv =====
// ----------------------------------------------------------------------------
// integer_literal_to_128bit
// Parses a decimal or 0x-prefixed hex literal, one character per beat,
// into a 128-bit value delivered as two 64-bit halves.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | char_code, last_char
//  out     | out_valid / out_stall| value_low, value_high, hex_base
//
//  one character per cycle, back to back while in_stall is low; a result
//  is registered once its last character has passed the input register
//  the 128-bit multiply-by-base and add lie between input and state
//  an input register and a result register part the two sides
//  arst_n clears the accumulator, prefix state and both valid flags
//  the input stalls only while a last character waits on a stalled result
module integer_literal_to_128bit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [il128_pkg::CHAR_W-1:0]        char_code,
	input  logic                                last_char,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [il128_pkg::HALF_W-1:0]        value_low,
	output logic [il128_pkg::HALF_W-1:0]        value_high,
	output logic                                hex_base
);

	logic                            valid_s1;
	logic [il128_pkg::CHAR_W-1:0]    char_s1;
	logic                            last_s1;

	logic [il128_pkg::ACC_W-1:0]     acc_q;
	il128_pkg::kept_t                kept_q;
	logic                            first_zero_q;
	logic                            hex_q;
	logic                            halted_q;

	logic                            valid_s2;
	logic [il128_pkg::ACC_W-1:0]     value_s2;
	logic                            hex_s2;

	logic                            out_free;
	logic                            go_s1;
	logic                            take_in;

	logic [il128_pkg::ACC_W-1:0]     acc_d;
	il128_pkg::kept_t                kept_d;
	logic                            first_zero_d;
	logic                            hex_d;
	logic                            halted_d;
	logic                            use_digit;
	logic                            digit_hex;
	il128_pkg::digit_t               dig;
	logic [il128_pkg::ACC_W-1:0]     scaled;

	assign out_free = !valid_s2 || !out_stall;
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !go_s1;
	assign take_in  = in_valid && !in_stall;

	assign digit_hex = (kept_q == il128_pkg::KEPT_TWO) && hex_q;
	assign dig       = il128_pkg::decode_digit(char_s1, digit_hex);
	assign scaled    = digit_hex ? (acc_q << 4) : ((acc_q << 3) + (acc_q << 1));

	always_comb begin
		kept_d       = kept_q;
		first_zero_d = first_zero_q;
		hex_d        = hex_q;
		halted_d     = halted_q;
		use_digit    = 1'b0;
		if (char_s1 != il128_pkg::CH_UNDERSCORE && !halted_q) begin
			case (kept_q)
				il128_pkg::KEPT_NONE: begin
					first_zero_d = (char_s1 == il128_pkg::CH_ZERO);
					use_digit    = 1'b1;
					kept_d       = il128_pkg::KEPT_ONE;
				end
				il128_pkg::KEPT_ONE: begin
					if (first_zero_q && (char_s1 == il128_pkg::CH_LOWER_X ||
						char_s1 == il128_pkg::CH_UPPER_X)) begin
						hex_d = 1'b1;
					end else begin
						use_digit = 1'b1;
					end
					kept_d = il128_pkg::KEPT_TWO;
				end
				default: begin
					use_digit = 1'b1;
				end
			endcase
		end
		acc_d = acc_q;
		if (use_digit) begin
			if (dig.ok) begin
				acc_d = scaled + {{(il128_pkg::ACC_W-il128_pkg::DIGIT_W){1'b0}}, dig.value};
			end else begin
				halted_d = 1'b1;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			kept_q       <= il128_pkg::KEPT_NONE;
			first_zero_q <= 1'b0;
			hex_q        <= 1'b0;
			halted_q     <= 1'b0;
		end else if (go_s1) begin
			if (last_s1) begin
				acc_q        <= '0;
				kept_q       <= il128_pkg::KEPT_NONE;
				first_zero_q <= 1'b0;
				hex_q        <= 1'b0;
				halted_q     <= 1'b0;
			end else begin
				acc_q        <= acc_d;
				kept_q       <= kept_d;
				first_zero_q <= first_zero_d;
				hex_q        <= hex_d;
				halted_q     <= halted_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			value_s2 <= acc_d;
			hex_s2   <= hex_d;
		end
	end

	assign out_valid  = valid_s2;
	assign value_low  = value_s2[il128_pkg::HALF_W-1:0];
	assign value_high = value_s2[il128_pkg::ACC_W-1:il128_pkg::HALF_W];
	assign hex_base   = hex_s2;

endmodule

// ===== sv/il128_checker.sv =====
// ----------------------------------------------------------------------------
// il128_checker
// Port-level checks for the literal parser, bound to the top level.
// ----------------------------------------------------------------------------
module il128_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last_char,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [il128_pkg::HALF_W-1:0]  value_low,
	input logic [il128_pkg::HALF_W-1:0]  value_high,
	input logic                          hex_base
);

	// no result while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high during reset");

	// the input only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// a taken last character yields a result
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_char |-> ##2 out_valid)
		else $error("no result after last character");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_low) &&
			$stable(value_high) && $stable(hex_base))
		else $error("stalled result changed");

endmodule

bind integer_literal_to_128bit il128_checker u_il128_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_char  (last_char),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.value_low  (value_low),
	.value_high (value_high),
	.hex_base   (hex_base)
);
